>>> hdl/apcd_pkg.sv
// ----------------------------------------------------------------------------
// apcd_pkg
// Shared types, constants and Q1.15 arithmetic helpers for the allpass
// cascade diffuser.
// ----------------------------------------------------------------------------
package apcd_pkg;

	// Q1.15 sample / coefficient word
	typedef logic signed [15:0] q15_t;

	// coefficient register file
	localparam int            NUM_COEFS  = 8;
	localparam int            CFG_IDX_W  = 4;
	localparam logic [15:0]   COEF_RESET = 16'h4000;  // 0.5

	// one sample moving down the chain of sections
	typedef struct packed {
		logic valid;
		logic ch;
		logic live;    // channel is present; otherwise the sample passes untouched
		q15_t sample;
	} beat_t;

	// product rounded to nearest, ties toward +inf; result spans 17 bits
	function automatic logic signed [16:0] mulq15(input q15_t a, input q15_t b);
		logic signed [31:0] p;
		p = a * b + 32'sd16384;
		return p[31:15];
	endfunction

	// clamp an 18-bit intermediate to the 16-bit range
	function automatic q15_t sat16(input logic signed [17:0] v);
		if (v > 18'sd32767) begin
			return 16'sh7fff;
		end else if (v < -18'sd32768) begin
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

endpackage

>>> hdl/apcd_coef_regs.sv
// ----------------------------------------------------------------------------
// apcd_coef_regs
// Coefficient register file, one Q1.15 word per section, written through
// the configuration channel. Indexes past the last register are dropped.
// ----------------------------------------------------------------------------
module apcd_coef_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic [apcd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                    cfg_data,
	output apcd_pkg::q15_t                 coef [apcd_pkg::NUM_COEFS]
);
	import apcd_pkg::*;

	q15_t coef_q [NUM_COEFS];

	// register write on each config transfer that hits the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_COEFS; i++) begin
				coef_q[i] <= COEF_RESET;
			end
		end else if (cfg_valid) begin
			for (int i = 0; i < NUM_COEFS; i++) begin
				if (cfg_index == CFG_IDX_W'(i)) begin
					coef_q[i] <= cfg_data;
				end
			end
		end
	end

	assign coef = coef_q;

endmodule

>>> hdl/apcd_cell.sv
// ----------------------------------------------------------------------------
// apcd_cell
// One first-order allpass section. Holds the delay word of every channel
// and works in two stages: t = x - a*z (delay updated here), y = a*t + z.
// ----------------------------------------------------------------------------
module apcd_cell #(
	parameter int NUM_CHANNELS = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  apcd_pkg::q15_t  coef,
	input  apcd_pkg::beat_t beat_i,
	output apcd_pkg::beat_t beat_o
);
	import apcd_pkg::*;

	// the channel field is one bit, so at most two delay words are reachable
	localparam int NUM_LIVE = (NUM_CHANNELS > 2) ? 2 : NUM_CHANNELS;

	q15_t                z_q [NUM_LIVE];
	logic                rd_idx;
	q15_t                z_rd;
	logic signed [16:0]  m1;
	logic signed [17:0]  diff;
	q15_t                t;

	logic                v_s1;
	logic                ch_s1;
	logic                live_s1;
	q15_t                t_s1;
	q15_t                z_s1;

	logic signed [16:0]  m2;
	logic signed [17:0]  sum;
	q15_t                y;
	logic                v_s2;
	logic                ch_s2;
	logic                live_s2;
	q15_t                sample_s2;

	// stage 1: feed-forward difference against the stored delay
	assign rd_idx = beat_i.live ? beat_i.ch : 1'b0;
	assign z_rd   = z_q[rd_idx];
	assign m1     = mulq15(coef, z_rd);
	assign diff   = {{2{beat_i.sample[15]}}, beat_i.sample} - {m1[16], m1};
	assign t      = sat16(diff);

	// delay words; written as the item leaves stage 1 so a follower sees it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LIVE; i++) begin
				z_q[i] <= '0;
			end
		end else if (en && beat_i.valid && beat_i.live) begin
			z_q[rd_idx] <= t;
		end
	end

	// stage 1 registers; a bypassed sample rides in t_s1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= beat_i.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ch_s1   <= beat_i.ch;
			live_s1 <= beat_i.live;
			t_s1    <= beat_i.live ? t : beat_i.sample;
			z_s1    <= z_rd;
		end
	end

	// stage 2: feedback sum
	assign m2  = mulq15(coef, t_s1);
	assign sum = {m2[16], m2} + {{2{z_s1[15]}}, z_s1};
	assign y   = sat16(sum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ch_s2     <= ch_s1;
			live_s2   <= live_s1;
			sample_s2 <= live_s1 ? y : t_s1;
		end
	end

	assign beat_o = '{valid: v_s2, ch: ch_s2, live: live_s2, sample: sample_s2};

`ifndef SYNTHESIS
	a_delay_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(en && beat_i.valid && beat_i.live && !beat_i.ch) |=> $stable(z_q[0]))
		else $error("delay word changed without a live transfer");

	a_stage_move: assert property (@(posedge clk) disable iff (!arst_n)
		en && v_s1 |=> v_s2)
		else $error("stage 1 item lost on advance");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_s1) && $stable(t_s1) && $stable(v_s2))
		else $error("cell moved while the chain was held");
`endif

endmodule

>>> hdl/allpass_cascade_diffuser_top.sv
// ----------------------------------------------------------------------------
// allpass_cascade_diffuser_top
// Cascade of first-order allpass sections over a multichannel sample stream.
// ----------------------------------------------------------------------------
// Throughput: one sample per cycle while the chain is not held; each section
// cell updates its delay word in its first stage, so a same-channel follower
// in the next cycle is exact. The whole chain holds while a finished sample
// waits under out_stall. Reset: arst_n clears all delay words to zero,
// empties the chain and loads every coefficient with 0.5. The user must change
// coefficients only while idle; the block itself does not enforce this.
module allpass_cascade_diffuser_top #(
	parameter int N_SECTIONS   = 8,
	parameter int NUM_CHANNELS = 2
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// sample input
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           channel,
	input  logic signed [15:0]             sample_in,
	// sample output
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           channel_out,
	output logic signed [15:0]             sample_out,
	// configuration
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [apcd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                    cfg_data
);
	import apcd_pkg::*;

	q15_t  coef [NUM_COEFS];
	beat_t link [N_SECTIONS+1];
	logic  en;

	assign cfg_ready = 1'b1;

	apcd_coef_regs u_coef (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coef      (coef)
	);

	// chain advances unless the output sample is held
	assign en       = !link[N_SECTIONS].valid || !out_stall;
	assign in_stall = !en;

	// head of the chain straight from the input ports
	assign link[0] = '{valid:  in_valid,
	                   ch:     channel,
	                   live:   (int'(channel) < NUM_CHANNELS),
	                   sample: sample_in};

	for (genvar s = 0; s < N_SECTIONS; s++) begin : g_cell
		apcd_cell #(
			.NUM_CHANNELS (NUM_CHANNELS)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.coef   (coef[s]),
			.beat_i (link[s]),
			.beat_o (link[s+1])
		);
	end

	assign out_valid   = link[N_SECTIONS].valid;
	assign channel_out = link[N_SECTIONS].ch;
	assign sample_out  = link[N_SECTIONS].sample;

`ifndef SYNTHESIS
	a_hold_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("input taken while output is held");

	a_empty_open: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with an empty output");

	a_cfg_ignore: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && (cfg_index >= CFG_IDX_W'(NUM_COEFS)) |=> $stable(coef[0]))
		else $error("out-of-range config write changed a coefficient");
`endif

endmodule

>>> tb/allpass_cascade_diffuser_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// allpass_cascade_diffuser_top_tb
// Drives channel-tagged Q1.15 samples through the allpass cascade and checks
// every output sample against a cycle-free predictor of the section chain,
// under bursty input, patterned output stalls and several coefficient sets.
// ----------------------------------------------------------------------------
module allpass_cascade_diffuser_top_tb;
	import apcd_pkg::*;

	localparam int N_SECTIONS      = 8;
	localparam int NUM_CHANNELS    = 2;
	localparam int LATENCY         = 2 * N_SECTIONS;
	localparam int HOLD_CYCLES     = 300;
	localparam int LIMIT_CYCLES    = 500000;
	localparam int PHASE_ITEMS     = 200;
	localparam int RANDOM_PHASES   = 8;
	localparam int FLOOD_ITEMS     = 60;

	// configuration register map
	localparam int REG_COEF_0      = 0;
	localparam int REG_SPARE_FIRST = NUM_COEFS;
	localparam int REG_LAST        = 2 ** CFG_IDX_W - 1;

	localparam q15_t Q15_MAX       = 16'sh7fff;
	localparam q15_t Q15_MIN       = 16'sh8000;
	localparam q15_t COEF_MAX      = 16'sd32764;
	localparam q15_t COEF_MIN      = -16'sd32764;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	typedef struct packed {
		logic ch;
		q15_t sample;
	} result_t;

	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 in_valid    = 1'b0;
	logic                 in_stall;
	logic                 channel     = 1'b0;
	q15_t                 sample_in   = '0;
	logic                 out_valid;
	logic                 out_stall   = 1'b0;
	logic                 channel_out;
	logic signed [15:0]   sample_out;
	logic                 cfg_valid   = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index   = '0;
	logic [15:0]          cfg_data    = '0;

	// predictor state
	q15_t    coef_shadow [NUM_COEFS];
	q15_t    delay_shadow [NUM_CHANNELS][N_SECTIONS];
	q15_t    coef_plan [NUM_COEFS];
	result_t pending_outputs [$];
	result_t oldest_result;

	int          err_count   = 0;
	int          cycle_count = 0;
	int          burst_left  = 0;
	bit          no_gaps     = 1'b0;
	logic        hold_toggle = 1'b0;
	logic        hold_seen   = 1'b0;
	int          hold_left   = 0;
	stall_mode_t stall_mode  = STALL_NONE;
	int          mode_left   = 0;
	int          stall_phase = 0;

	allpass_cascade_diffuser_top #(
		.N_SECTIONS   (N_SECTIONS),
		.NUM_CHANNELS (NUM_CHANNELS)
	) uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.channel     (channel),
		.sample_in   (sample_in),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.channel_out (channel_out),
		.sample_out  (sample_out),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	// 50 MHz clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Q1.15 product, round to nearest with ties up
	function automatic int round_mul(input int a, input int b);
		int p;
		p = a * b + 16384;
		return p >>> 15;
	endfunction

	function automatic int clamp_q15(input int v);
		if (v > 32767) begin
			return 32767;
		end else if (v < -32768) begin
			return -32768;
		end
		return v;
	endfunction

	// run one sample through the section chain, updating the delay words
	function automatic result_t diffuse_predict(input logic ch, input q15_t x_in);
		result_t r;
		int      x;
		int      a;
		int      z;
		int      t;
		x = x_in;
		if (int'(ch) < NUM_CHANNELS) begin
			for (int s = 0; s < N_SECTIONS; s++) begin
				a = coef_shadow[s];
				z = delay_shadow[ch][s];
				t = clamp_q15(x - round_mul(a, z));
				x = clamp_q15(round_mul(a, t) + z);
				delay_shadow[ch][s] = q15_t'(t);
			end
		end
		r.ch     = ch;
		r.sample = q15_t'(x);
		return r;
	endfunction

	function automatic q15_t random_sample();
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 4))
					0: return Q15_MAX;
					1: return Q15_MIN;
					2: return 16'sd0;
					3: return 16'sd1;
					default: return -16'sd1;
				endcase
			end
			1, 2: return q15_t'(int'($urandom_range(0, 511)) - 256);
			default: return q15_t'($urandom);
		endcase
	endfunction

	function automatic q15_t random_coef();
		case ($urandom_range(0, 15))
			0: return COEF_MAX;
			1: return COEF_MIN;
			2: return Q15_MIN;
			3: return 16'sd0;
			default: return q15_t'(int'($urandom_range(0, 65528)) - 32764);
		endcase
	endfunction

	// one register write; cfg_valid stays high for a following write
	task automatic cfg_write(input int idx, input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_IDX_W'(idx);
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		if (idx < NUM_COEFS) begin
			coef_shadow[idx] = q15_t'(value);
		end
	endtask

	// write coef_plan to all sections, then a few writes to unused indexes
	task automatic load_coef_plan(input int spare_writes);
		for (int s = 0; s < NUM_COEFS; s++) begin
			cfg_write(REG_COEF_0 + s, coef_plan[s]);
		end
		for (int i = 0; i < spare_writes; i++) begin
			cfg_write($urandom_range(REG_SPARE_FIRST, REG_LAST), 16'($urandom));
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic plan_all(input q15_t value);
		for (int s = 0; s < NUM_COEFS; s++) begin
			coef_plan[s] = value;
		end
	endtask

	// offer one sample, inserting a random gap at the end of each burst
	task automatic send_sample(input logic ch, input q15_t x);
		int gap;
		if (!no_gaps && burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
			                                          : $urandom_range(1, 20);
		end
		if (burst_left > 0) begin
			burst_left--;
		end
		in_valid  <= 1'b1;
		channel   <= ch;
		sample_in <= x;
		do @(posedge clk); while (in_stall);
		pending_outputs.insert(pending_outputs.size(), diffuse_predict(ch, x));
	endtask

	// stop offering and wait until every expected output has arrived
	task automatic wait_for_results();
		in_valid   <= 1'b0;
		burst_left = 0;
		while (pending_outputs.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	// reset coefficients of 0.5; full-scale steps and same-channel followers
	task automatic test_default_coefs();
		send_sample(1'b0, Q15_MAX);
		send_sample(1'b0, Q15_MAX);
		send_sample(1'b1, Q15_MIN);
		send_sample(1'b1, Q15_MIN);
		send_sample(1'b0, 16'sd0);
		send_sample(1'b1, 16'sd1);
		send_sample(1'b0, -16'sd1);
		send_sample(1'b1, Q15_MAX);
		wait_for_results();
	endtask

	// extreme coefficients, including -1.0 which lies outside COEF_MIN to COEF_MAX
	task automatic test_coef_extremes();
		plan_all(COEF_MAX);
		load_coef_plan(0);
		send_sample(1'b0, Q15_MIN);
		send_sample(1'b0, Q15_MAX);
		send_sample(1'b1, Q15_MAX);
		wait_for_results();

		plan_all(COEF_MIN);
		load_coef_plan(0);
		send_sample(1'b0, Q15_MAX);
		send_sample(1'b1, Q15_MIN);
		send_sample(1'b0, Q15_MIN);
		wait_for_results();

		plan_all(Q15_MIN);
		load_coef_plan(0);
		send_sample(1'b0, Q15_MAX);
		send_sample(1'b0, Q15_MIN);
		send_sample(1'b1, Q15_MAX);
		send_sample(1'b1, -16'sd1);
		wait_for_results();

		// alternate zero and -1.0 across the sections
		for (int s = 0; s < NUM_COEFS; s++) begin
			coef_plan[s] = (s % 2 == 0) ? 16'sd0 : Q15_MIN;
		end
		load_coef_plan(0);
		send_sample(1'b1, Q15_MIN);
		send_sample(1'b0, Q15_MAX);
		wait_for_results();
	endtask

	// writes past coef_7 must leave every coefficient alone
	task automatic test_spare_indexes();
		for (int i = REG_SPARE_FIRST; i <= REG_LAST; i++) begin
			cfg_write(i, 16'h8000 ^ 16'(i));
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
		send_sample(1'b0, 16'sd12345);
		send_sample(1'b1, -16'sd12345);
		wait_for_results();
	endtask

	// receiver holds off while the sender keeps offering back to back
	task automatic test_output_holdoff();
		no_gaps = 1'b1;
		hold_toggle <= ~hold_toggle;
		for (int i = 0; i < FLOOD_ITEMS; i++) begin
			send_sample(1'($urandom_range(0, 1)), random_sample());
		end
		no_gaps = 1'b0;
		wait_for_results();
	endtask

	// random coefficient sets, each followed by a stream of random samples
	task automatic test_random_phases();
		logic ch;
		ch = 1'b0;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			for (int s = 0; s < NUM_COEFS; s++) begin
				coef_plan[s] = random_coef();
			end
			load_coef_plan($urandom_range(0, 2));
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// sender pauses mid-phase until the chain has drained
				if (ph == 3 && i == PHASE_ITEMS / 2) begin
					wait_for_results();
				end
				if ($urandom_range(0, 3) == 0) begin
					ch = ~ch;
				end
				send_sample(ch, random_sample());
			end
			wait_for_results();
		end
	endtask

	// output checker
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_outputs.size() == 0) begin
				$display("%0t: unexpected output, channel %0d sample %0d",
				         $time, channel_out, sample_out);
				err_count++;
			end else begin
				oldest_result = pending_outputs.pop_front();
				if (channel_out !== oldest_result.ch) begin
					$display("%0t: channel_out mismatch, expected %0d actual %0d",
					         $time, oldest_result.ch, channel_out);
					err_count++;
				end
				if (sample_out !== oldest_result.sample) begin
					$display("%0t: sample_out mismatch, expected %0d actual %0d",
					         $time, oldest_result.sample, sample_out);
					err_count++;
				end
			end
		end
	end

	// receiver stall pattern, with a long hold-off on request
	always @(posedge clk) begin
		stall_phase <= stall_phase + 1;
		if (hold_toggle != hold_seen) begin
			hold_seen <= hold_toggle;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				stall_mode <= stall_mode_t'($urandom_range(0, 3));
				mode_left  <= $urandom_range(50, 300);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (stall_mode)
				STALL_NONE:     out_stall <= 1'b0;
				STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY:    out_stall <= ($urandom_range(0, 9) < 6);
				STALL_PERIODIC: out_stall <= (stall_phase % 3 == 0);
				default:        out_stall <= 1'b0;
			endcase
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		for (int s = 0; s < NUM_COEFS; s++) begin
			coef_shadow[s] = q15_t'(COEF_RESET);
		end
		for (int c = 0; c < NUM_CHANNELS; c++) begin
			for (int s = 0; s < N_SECTIONS; s++) begin
				delay_shadow[c][s] = '0;
			end
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_coefs();
		test_coef_extremes();
		test_spare_indexes();
		test_output_holdoff();
		test_random_phases();

		wait_for_results();
		repeat (LATENCY + 8) @(posedge clk);
		if (err_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

>>> files.f
hdl/apcd_pkg.sv
hdl/apcd_coef_regs.sv
hdl/apcd_cell.sv
hdl/allpass_cascade_diffuser_top.sv
tb/allpass_cascade_diffuser_top_tb.sv
